>>> rtl/tcp_stream_reassembler_unit_macros.svh
// ----------------------------------------------------------------------------
// tcp stream reassembler assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef TCP_STREAM_REASSEMBLER_UNIT_MACROS_SVH
`define TCP_STREAM_REASSEMBLER_UNIT_MACROS_SVH

// same-cycle implication
`define TSR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tsr assertion failed");

// next-cycle implication
`define TSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tsr assertion failed");

`endif

>>> rtl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// shared types and constants of the tcp stream reassembler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsr_pkg;

  localparam int WINDOW_BYTES_DEF = 64;
  localparam int QUEUE_DEPTH      = 2;
  localparam int IDX_W            = 32;
  localparam int DATA_W           = 8;
  localparam int CNT_W            = 7;
  localparam int CNT_MAX          = 127;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_END  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_END,
    OP_READ,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              set_end;
    logic [IDX_W-1:0]  end_val;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_byte;
    logic              read_valid;
    logic              byte_stored;
    logic [IDX_W-1:0]  assembled_end;
    logic [CNT_W-1:0]  pending_count;
    logic              input_ended;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_WR,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_READ,
    ST_FINISH
  } state_e;

endpackage

>>> rtl/tsr_front.sv
// ----------------------------------------------------------------------------
// tsr_front
// accepts input beats, decodes the command and queues a classified item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsr_front import tsr_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [IDX_W-1:0]  stream_index_i,
  input  logic [DATA_W-1:0] data_byte_i,
  input  logic              is_last_byte_i,
  input  logic              clearing_i,
  input  qstat_t            q_stat_i,
  output logic              q_push_o,
  output item_t             q_item_o
);

  assign in_stall_o = q_stat_i.full | clearing_i;
  assign q_push_o   = in_valid_i & ~in_stall_o;

  always_comb begin
    q_item_o.idx     = stream_index_i;
    q_item_o.data    = data_byte_i;
    q_item_o.end_val = stream_index_i;
    q_item_o.set_end = 1'b0;
    q_item_o.op      = OP_NOP;
    unique case (cmd_e'(cmd_i))
      CMD_PUSH: begin
        q_item_o.op      = OP_PUSH;
        q_item_o.set_end = is_last_byte_i;
        q_item_o.end_val = stream_index_i + IDX_W'(1);
      end
      CMD_END: begin
        q_item_o.op      = OP_END;
        q_item_o.set_end = 1'b1;
      end
      CMD_READ: begin
        q_item_o.op = OP_READ;
      end
      CMD_NOP: begin
        q_item_o.op = OP_NOP;
      end
    endcase
  end

endmodule

>>> rtl/tsr_queue.sv
// ----------------------------------------------------------------------------
// tsr_queue
// short item queue between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsr_queue import tsr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  item_t  item_i,
  input  logic   pop_i,
  output item_t  item_o,
  output qstat_t stat_o
);

  `include "tcp_stream_reassembler_unit_macros.svh"

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  item_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_QW-1:0]  cnt_q, cnt_d;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == CNT_QW'(QUEUE_DEPTH));
  assign item_o       = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ptr_next(wptr_q) : wptr_q;
    rptr_d = pop_i  ? ptr_next(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_QW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  `TSR_ASSERT_IMPL(a_no_overflow, stat_o.full, !push_i)
  `TSR_ASSERT_IMPL(a_no_underflow, !stat_o.valid, !pop_i)
  `TSR_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CNT_QW'(QUEUE_DEPTH))

endmodule

>>> rtl/tsr_back.sv
// ----------------------------------------------------------------------------
// tsr_back
// executes queued items: byte ring, valid map walk, reads and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsr_back import tsr_pkg::*; #(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  qstat_t  q_stat_i,
  input  item_t   q_item_i,
  output logic    q_pop_o,
  output logic    clearing_o,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output result_t result_o
);

  `include "tcp_stream_reassembler_unit_macros.svh"

  localparam int SW = $clog2(WINDOW_BYTES);
  localparam int PW = $clog2(WINDOW_BYTES + 1);
  localparam logic [SW:0]      WIN      = (SW + 1)'(WINDOW_BYTES);
  localparam logic [SW-1:0]    SLOT_MAX = SW'(WINDOW_BYTES - 1);
  localparam logic [IDX_W-1:0] WIN_IDX  = IDX_W'(WINDOW_BYTES);

  state_e            state_q, state_d;
  item_t             cur_q, cur_d;
  logic [IDX_W-1:0]  ap_q, ap_d, rp_q, rp_d, endpos_q, endpos_d;
  logic [SW-1:0]     aslot_q, aslot_d, rslot_q, rslot_d, slot_q, slot_d, clr_q, clr_d;
  logic              endknown_q, endknown_d, ended_q, ended_d;
  logic [PW-1:0]     pending_q, pending_d;
  logic              stored_q, stored_d, rvalid_q, rvalid_d;
  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;

  logic [DATA_W-1:0] ring_mem [WINDOW_BYTES];
  logic              vmap_mem [WINDOW_BYTES];
  logic [DATA_W-1:0] ring_rd_q;
  logic              vmap_rd_q;

  logic              ring_we, ring_re, vmap_we, vmap_re, vmap_wd;
  logic [SW-1:0]     ring_raddr, vmap_waddr, vmap_raddr;

  logic [IDX_W-1:0]  off, lim, ap_inc, rp_inc;
  logic              in_win, wrapped, can_walk, done_now;
  logic [SW:0]       slot_sum, slot_mod;
  logic [SW-1:0]     push_slot, aslot_nxt, rslot_nxt;

  assign off       = cur_q.idx - ap_q;
  assign lim       = rp_q + WIN_IDX - ap_q;
  assign in_win    = off < lim;
  assign wrapped   = cur_q.idx < ap_q;
  assign slot_sum  = {1'b0, aslot_q} + {1'b0, off[SW-1:0]};
  assign slot_mod  = (slot_sum >= WIN) ? slot_sum - WIN : slot_sum;
  assign push_slot = wrapped ? cur_q.idx[SW-1:0] : slot_mod[SW-1:0];
  assign can_walk  = (ap_q - rp_q) < WIN_IDX;
  assign ap_inc    = ap_q + IDX_W'(1);
  assign rp_inc    = rp_q + IDX_W'(1);
  // slot follows index mod window, back to zero at the index wrap
  assign aslot_nxt = (ap_inc == '0) ? '0 : (aslot_q == SLOT_MAX) ? '0 : aslot_q + SW'(1);
  assign rslot_nxt = (rp_inc == '0) ? '0 : (rslot_q == SLOT_MAX) ? '0 : rslot_q + SW'(1);
  assign done_now  = endknown_q && (pending_q == '0) && (ap_q >= endpos_q);

  assign clearing_o  = (state_q == ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    ap_d        = ap_q;
    rp_d        = rp_q;
    endpos_d    = endpos_q;
    aslot_d     = aslot_q;
    rslot_d     = rslot_q;
    slot_d      = slot_q;
    clr_d       = clr_q;
    endknown_d  = endknown_q;
    ended_d     = ended_q;
    pending_d   = pending_q;
    stored_d    = stored_q;
    rvalid_d    = rvalid_q;
    out_valid_d = out_valid_q & out_stall_i;
    res_d       = res_q;
    q_pop_o     = 1'b0;
    ring_we     = 1'b0;
    ring_re     = 1'b0;
    ring_raddr  = rslot_q;
    vmap_we     = 1'b0;
    vmap_re     = 1'b0;
    vmap_wd     = 1'b0;
    vmap_waddr  = clr_q;
    vmap_raddr  = aslot_q;

    unique case (state_q)
      ST_CLEAR: begin
        vmap_we    = 1'b1;
        vmap_waddr = clr_q;
        clr_d      = clr_q + SW'(1);
        if (clr_q == SLOT_MAX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_stat_i.valid) begin
          q_pop_o  = 1'b1;
          cur_d    = q_item_i;
          stored_d = 1'b0;
          rvalid_d = 1'b0;
          if (q_item_i.set_end) begin
            endpos_d   = q_item_i.end_val;
            endknown_d = 1'b1;
          end
          unique case (q_item_i.op) inside
            OP_PUSH:        state_d = ST_PUSH_RD;
            OP_READ:        state_d = ST_READ;
            OP_END, OP_NOP: state_d = ST_FINISH;
          endcase
        end
      end
      ST_PUSH_RD: begin
        if (in_win) begin
          vmap_re    = 1'b1;
          vmap_raddr = push_slot;
          slot_d     = push_slot;
          state_d    = ST_PUSH_WR;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_PUSH_WR: begin
        ring_we    = 1'b1;
        vmap_we    = 1'b1;
        vmap_wd    = 1'b1;
        vmap_waddr = slot_q;
        stored_d   = 1'b1;
        if (!vmap_rd_q) begin
          pending_d = pending_q + PW'(1);
        end
        state_d = ST_WALK_RD;
      end
      ST_WALK_RD: begin
        if (can_walk) begin
          vmap_re    = 1'b1;
          vmap_raddr = aslot_q;
          state_d    = ST_WALK_CHK;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_WALK_CHK: begin
        if (vmap_rd_q) begin
          vmap_we    = 1'b1;
          vmap_waddr = aslot_q;
          if (pending_q != '0) begin
            pending_d = pending_q - PW'(1);
          end
          ap_d    = ap_inc;
          aslot_d = aslot_nxt;
          state_d = ST_WALK_RD;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_READ: begin
        if (rp_q != ap_q) begin
          ring_re  = 1'b1;
          rvalid_d = 1'b1;
          rp_d     = rp_inc;
          rslot_d  = rslot_nxt;
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          ended_d             = ended_q | done_now;
          res_d.read_byte     = rvalid_q ? ring_rd_q : '0;
          res_d.read_valid    = rvalid_q;
          res_d.byte_stored   = stored_q;
          res_d.assembled_end = ap_q;
          res_d.pending_count = (32'(pending_q) > CNT_MAX) ? CNT_W'(CNT_MAX)
                                                           : CNT_W'(pending_q);
          res_d.input_ended   = ended_q | done_now;
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ap_q        <= '0;
      rp_q        <= '0;
      endpos_q    <= '0;
      aslot_q     <= '0;
      rslot_q     <= '0;
      clr_q       <= '0;
      endknown_q  <= 1'b0;
      ended_q     <= 1'b0;
      pending_q   <= '0;
      stored_q    <= 1'b0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ap_q        <= ap_d;
      rp_q        <= rp_d;
      endpos_q    <= endpos_d;
      aslot_q     <= aslot_d;
      rslot_q     <= rslot_d;
      clr_q       <= clr_d;
      endknown_q  <= endknown_d;
      ended_q     <= ended_d;
      pending_q   <= pending_d;
      stored_q    <= stored_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    slot_q <= slot_d;
    res_q  <= res_d;
  end

  // byte ring
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[slot_q] <= cur_q.data;
    end
    if (ring_re) begin
      ring_rd_q <= ring_mem[ring_raddr];
    end
  end

  // valid map
  always_ff @(posedge clk_i) begin
    if (vmap_we) begin
      vmap_mem[vmap_waddr] <= vmap_wd;
    end
    if (vmap_re) begin
      vmap_rd_q <= vmap_mem[vmap_raddr];
    end
  end

  `TSR_ASSERT_IMPL(a_window_span, 1'b1, (ap_q - rp_q) <= WIN_IDX)
  `TSR_ASSERT_NEXT(a_walk_step, (state_q == ST_WALK_CHK) && vmap_rd_q, ap_q == $past(ap_q) + IDX_W'(1))
  `TSR_ASSERT_NEXT(a_ended_sticky, ended_q, ended_q)
  `TSR_ASSERT_IMPL(a_pop_only_idle, state_q != ST_IDLE, !q_pop_o)

endmodule

>>> rtl/tcp_stream_reassembler_unit.sv
// ----------------------------------------------------------------------------
// tcp_stream_reassembler_unit
// puts an out-of-order byte stream back in order, one stream byte per beat
// ----------------------------------------------------------------------------
// usage
//   input beat: cmd_i (push byte, mark end, read byte, no-op), stream_index_i,
//   data_byte_i, is_last_byte_i; taken when in_valid_i is high and in_stall_o
//   is low. every input beat yields exactly one output beat, in order, taken
//   when out_valid_o is high and out_stall_i is low.
//   a two-entry queue sits behind the decoder, so beats keep arriving while
//   the executor works or while a result waits on a stalled receiver; once the
//   queue is full in_stall_o rises.
//   path from queue to result register: end mark or no-op go from idle to the
//   finish state, a read passes the read state, a push reads the map and is
//   dropped when outside the window, otherwise it writes ring and map and
//   walks the valid map, one read and one write of the map memory per byte
//   the assembled point moves past, stopping at a gap or the window limit.
//   after reset the valid map is cleared one entry a cycle, with in_stall_o
//   held high; all pointers and flags restart at zero.
//   a stalled result holds its value until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_stream_reassembler_unit import tsr_pkg::*; #(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [IDX_W-1:0]  stream_index_i,
  input  logic [DATA_W-1:0] data_byte_i,
  input  logic              is_last_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] read_byte_o,
  output logic              read_valid_o,
  output logic              byte_stored_o,
  output logic [IDX_W-1:0]  assembled_end_o,
  output logic [CNT_W-1:0]  pending_count_o,
  output logic              input_ended_o
);

  qstat_t  q_stat;
  item_t   q_item_in, q_item_out;
  logic    q_push, q_pop, clearing;
  result_t result;

  tsr_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .stream_index_i (stream_index_i),
    .data_byte_i    (data_byte_i),
    .is_last_byte_i (is_last_byte_i),
    .clearing_i     (clearing),
    .q_stat_i       (q_stat),
    .q_push_o       (q_push),
    .q_item_o       (q_item_in)
  );

  tsr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_item_in),
    .pop_i  (q_pop),
    .item_o (q_item_out),
    .stat_o (q_stat)
  );

  tsr_back #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_item_i    (q_item_out),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  assign read_byte_o     = result.read_byte;
  assign read_valid_o    = result.read_valid;
  assign byte_stored_o   = result.byte_stored;
  assign assembled_end_o = result.assembled_end;
  assign pending_count_o = result.pending_count;
  assign input_ended_o   = result.input_ended;

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives tcp_stream_reassembler_unit with corner beats and then shuffled byte
// traffic with retransmits, reads and end marks; a reordering predictor runs
// beside the unit and every result beat is compared with it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench import tsr_pkg::*;;

  localparam int unsigned WIN          = WINDOW_BYTES_DEF;
  localparam int          RANDOM_BEATS = 1000;
  localparam int          IDLE_LIMIT   = 4000;
  localparam int          TAIL_CYCLES  = 200;

  class reassembly_scoreboard;
    logic [DATA_W-1:0] ring [WIN];
    bit                filled [WIN];
    bit [IDX_W-1:0]    asm_pt;
    bit [IDX_W-1:0]    rd_pt;
    bit [IDX_W-1:0]    end_pos;
    bit                end_known;
    bit                ended;
    int unsigned       waiting_bytes;
    result_t           due_q[$];
    int unsigned       beats;
    int unsigned       checked;
    int unsigned       kept;
    int unsigned       served;
    int unsigned       mismatches;

    function void note_beat(cmd_e c, bit [IDX_W-1:0] idx, bit [DATA_W-1:0] data, bit last);
      result_t        r;
      bit [IDX_W-1:0] off;
      bit [IDX_W-1:0] lim;
      bit [IDX_W-1:0] lead;
      int unsigned    steps;
      r = '0;
      beats++;
      case (c)
        CMD_PUSH: begin
          if (last) begin
            end_pos   = idx + 1;
            end_known = 1'b1;
          end
          off = idx - asm_pt;
          lim = rd_pt + WIN - asm_pt;
          if (off < lim) begin
            ring[idx % WIN] = data;
            if (!filled[idx % WIN]) begin
              filled[idx % WIN] = 1'b1;
              waiting_bytes++;
            end
            r.byte_stored = 1'b1;
            kept++;
            steps = 0;
            lead  = asm_pt - rd_pt;
            while (steps < WIN && lead < WIN && filled[asm_pt % WIN]) begin
              filled[asm_pt % WIN] = 1'b0;
              if (waiting_bytes > 0) waiting_bytes--;
              asm_pt++;
              steps++;
              lead = asm_pt - rd_pt;
            end
          end
        end
        CMD_END: begin
          end_pos   = idx;
          end_known = 1'b1;
        end
        CMD_READ: begin
          if (rd_pt != asm_pt) begin
            r.read_byte  = ring[rd_pt % WIN];
            r.read_valid = 1'b1;
            rd_pt++;
            served++;
          end
        end
        default: ;
      endcase
      if (end_known && waiting_bytes == 0 && asm_pt >= end_pos) ended = 1'b1;
      r.assembled_end = asm_pt;
      r.pending_count = (waiting_bytes > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(waiting_bytes);
      r.input_ended   = ended;
      due_q.push_back(r);
    endfunction

    function void check_beat(logic [DATA_W-1:0] rb, logic rv, logic bs, logic [IDX_W-1:0] ae,
                             logic [CNT_W-1:0] pc, logic ie);
      result_t e;
      if (due_q.size() == 0) begin
        $error("result beat with no input beat outstanding");
        mismatches++;
        return;
      end
      e = due_q.pop_front();
      checked++;
      if (rb !== e.read_byte) begin
        $error("read_byte: expected %0h, got %0h", e.read_byte, rb);
        mismatches++;
      end
      if (rv !== e.read_valid) begin
        $error("read_valid: expected %0b, got %0b", e.read_valid, rv);
        mismatches++;
      end
      if (bs !== e.byte_stored) begin
        $error("byte_stored: expected %0b, got %0b", e.byte_stored, bs);
        mismatches++;
      end
      if (ae !== e.assembled_end) begin
        $error("assembled_end: expected %0h, got %0h", e.assembled_end, ae);
        mismatches++;
      end
      if (pc !== e.pending_count) begin
        $error("pending_count: expected %0d, got %0d", e.pending_count, pc);
        mismatches++;
      end
      if (ie !== e.input_ended) begin
        $error("input_ended: expected %0b, got %0b", e.input_ended, ie);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic [1:0]        cmd_i          = CMD_NOP;
  logic [IDX_W-1:0]  stream_index_i = '0;
  logic [DATA_W-1:0] data_byte_i    = '0;
  logic              is_last_byte_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic [DATA_W-1:0] read_byte_o;
  logic              read_valid_o;
  logic              byte_stored_o;
  logic [IDX_W-1:0]  assembled_end_o;
  logic [CNT_W-1:0]  pending_count_o;
  logic              input_ended_o;

  reassembly_scoreboard sb = new;
  int unsigned          burst_left = 1;

  tcp_stream_reassembler_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .stream_index_i  (stream_index_i),
    .data_byte_i     (data_byte_i),
    .is_last_byte_i  (is_last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_byte_o     (read_byte_o),
    .read_valid_o    (read_valid_o),
    .byte_stored_o   (byte_stored_o),
    .assembled_end_o (assembled_end_o),
    .pending_count_o (pending_count_o),
    .input_ended_o   (input_ended_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic pace_sender();
    int unsigned gap;
    gap = 0;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(0, 6);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drive_beat(input cmd_e c, input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] data, input logic last);
    in_valid_i     <= 1'b1;
    cmd_i          <= c;
    stream_index_i <= idx;
    data_byte_i    <= data;
    is_last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_beat(c, idx, data, last);
    pace_sender();
  endtask

  // far end marks keep the sticky end flag clear until the closing stretch
  task automatic send_traffic_beat(input bit late, input int unsigned read_share);
    int unsigned       r;
    cmd_e              c;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    logic              last;
    r    = $urandom_range(0, 99);
    idx  = $urandom;
    data = $urandom;
    last = 1'b0;
    if (r < 8) begin
      c    = cmd_e'($urandom_range(0, 3));
      last = $urandom_range(0, 1);
      if (!late && (c == CMD_END || (c == CMD_PUSH && last)))
        idx = sb.asm_pt + $urandom_range(32'h0010_0000, 32'h7fff_ffff);
    end else if (r < 12) begin
      c = CMD_END;
      if (late) idx = sb.asm_pt + $urandom_range(0, 24) - 4;
      else idx = sb.asm_pt + $urandom_range(32'h0010_0000, 32'h7fff_ffff);
    end else if (r < 12 + read_share) begin
      c = CMD_READ;
    end else begin
      c = CMD_PUSH;
      case ($urandom_range(0, 9))
        0:       idx = sb.asm_pt - $urandom_range(1, 3);
        1:       idx = sb.asm_pt + $urandom_range(0, 70);
        2, 3, 4: idx = sb.asm_pt + $urandom_range(1, 6);
        default: idx = sb.asm_pt;
      endcase
      last = late && ($urandom_range(0, 15) == 0);
    end
    drive_beat(c, idx, data, last);
  endtask

  initial begin : receiver_stall
    int unsigned mode;
    int unsigned len;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(4, 40);
      repeat (len) begin
        @(posedge clk_i);
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 1) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i)
      sb.check_beat(read_byte_o, read_valid_o, byte_stored_o, assembled_end_o,
                    pending_count_o, input_ended_o);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("[tcp_stream_reassembler_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned read_share;
    int unsigned phase_left;
    read_share = 30;
    phase_left = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner beats
    drive_beat(CMD_READ, 32'hffff_ffff, 8'hff, 1'b1);
    drive_beat(CMD_NOP,  32'hffff_ffff, 8'hff, 1'b1);
    drive_beat(CMD_END,  32'hffff_ffff, 8'h00, 1'b0);
    drive_beat(CMD_PUSH, 32'd1,         8'hff, 1'b0);
    drive_beat(CMD_PUSH, 32'd1,         8'h00, 1'b0);
    drive_beat(CMD_PUSH, 32'd64,        8'h11, 1'b1);
    drive_beat(CMD_PUSH, 32'd63,        8'ha5, 1'b0);
    drive_beat(CMD_PUSH, 32'd0,         8'h5a, 1'b0);
    drive_beat(CMD_PUSH, 32'd0,         8'h77, 1'b0);
    drive_beat(CMD_PUSH, 32'hffff_ffff, 8'h33, 1'b0);
    drive_beat(CMD_PUSH, 32'h8000_0000, 8'hcc, 1'b0);
    drive_beat(CMD_READ, 32'h0000_0000, 8'h00, 1'b0);
    drive_beat(CMD_READ, 32'h0000_0000, 8'h00, 1'b0);
    drive_beat(CMD_READ, 32'h0000_0000, 8'h00, 1'b0);
    drive_beat(CMD_END,  32'd3,         8'h00, 1'b0);
    drive_beat(CMD_END,  32'h7fff_ffff, 8'h00, 1'b0);
    drive_beat(CMD_NOP,  32'h0000_0000, 8'h00, 1'b0);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(100, 250);
        case ($urandom_range(0, 2))
          0:       read_share = 5;
          1:       read_share = 30;
          default: read_share = 60;
        endcase
      end
      phase_left--;
      send_traffic_beat(n >= RANDOM_BEATS * 9 / 10, read_share);
    end
    in_valid_i <= 1'b0;

    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d beats, %0d results compared, %0d bytes kept, %0d bytes read back",
             sb.beats, sb.checked, sb.kept, sb.served);
    $display("stream assembled up to %0d, end of input seen %0b", sb.asm_pt, sb.ended);
    if (sb.mismatches == 0 && sb.due_q.size() == 0)
      $display("[tcp_stream_reassembler_unit] OK");
    else
      $display("[tcp_stream_reassembler_unit] ERROR");
    $finish;
  end

endmodule
